@@ rtl/optb_pkg.sv @@
// Shared types and constants for the one-shot/periodic timer bank.
// Holds command and mode codes, the transaction payload structs and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package optb_pkg;

  // Slot field is 3 bits wide, so at most eight slots are addressable
  localparam int unsigned MaxSlots        = 8;
  localparam int unsigned NumSlotsDefault = 8;
  localparam int unsigned SlotW           = 3;
  localparam int unsigned DelayW          = 32;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_POLL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_SINGLE  = 2'd1,
    MODE_LOOP    = 2'd2
  } slot_mode_t;

  typedef struct packed {
    cmd_t              command;
    logic [SlotW-1:0]  slot;
    logic              mode;
    logic [DelayW-1:0] delay_ms;
  } in_t;

  typedef struct packed {
    logic             fired;
    logic [SlotW-1:0] fired_slot;
    logic             last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec_setup;  // apply a start or stop transaction
    logic walk_start;  // rewind the list walk
    logic tick_step;   // decrement one listed countdown
    logic poll_step;   // examine one listed slot for expiry
    logic flush_step;  // emit the final result of a poll
  } dp_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic list_empty;
    logic walk_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/oneshot_periodic_timer_bank.sv @@
// Bank of software timer slots, each stopped, one-shot or periodic. A start or
// stop transaction is applied as soon as it is accepted. A tick walks the
// insertion-order list one slot per cycle through a single countdown
// decrementer. A poll walks the list the same way and then emits its final
// result; each fired slot leaves through a one-entry output register, and a
// stalled output holds the walk. A poll gives one result per fired slot in list
// order, last set on the final one, or a single result with fired clear if
// nothing expired. Start and stop on a slot at or beyond NUM_SLOTS are dropped.
// Depends on optb_pkg.
`default_nettype none

module oneshot_periodic_timer_bank #(
  parameter int unsigned NUM_SLOTS = optb_pkg::NumSlotsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire optb_pkg::in_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output optb_pkg::out_t      out_item
);
  import optb_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // Sequence transactions
  optb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (in_item.command),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Hold slot state and the result register
  optb_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/optb_ctrl.sv @@
// Controller state machine of the timer bank.
// Sequences start/stop, tick walks, poll walks and the final poll result.
// Depends on optb_pkg.
`default_nettype none

module optb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire optb_pkg::cmd_t    command,
  input  wire optb_pkg::dp_stat_t stat,
  output optb_pkg::dp_ctl_t      ctl
);
  import optb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TICK  = 4'b0010,
    ST_POLL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Decode the transaction and step the walk
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command) inside
            CMD_START, CMD_STOP: begin
              ctl.exec_setup = 1'b1;
            end
            CMD_TICK: begin
              ctl.walk_start = 1'b1;
              if (!stat.list_empty) state_next = ST_TICK;
            end
            CMD_POLL: begin
              ctl.walk_start = 1'b1;
              state_next     = stat.list_empty ? ST_FLUSH : ST_POLL;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        ctl.tick_step = 1'b1;
        if (stat.walk_last) state_next = ST_IDLE;
      end
      ST_POLL: begin
        // Hold the walk while the output register is occupied
        if (stat.out_free) begin
          ctl.poll_step = 1'b1;
          if (stat.walk_last) state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          ctl.flush_step = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/optb_dp.sv @@
// Datapath of the timer bank: slot registers, insertion-order list,
// walk index, pending result and output register.
// Depends on optb_pkg.
`default_nettype none

module optb_dp #(
  parameter int unsigned NUM_SLOTS = optb_pkg::NumSlotsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire optb_pkg::in_t       in_item,
  input  wire optb_pkg::dp_ctl_t   ctl,
  output optb_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output optb_pkg::out_t           out_item
);
  import optb_pkg::*;

  // Slots beyond the reach of the slot field can never be started
  localparam int unsigned Depth = (NUM_SLOTS < MaxSlots) ? NUM_SLOTS : MaxSlots;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LenW  = $clog2(Depth + 1);
  localparam int unsigned CmpW  = SlotW + 1;

  slot_mode_t        slot_mode     [Depth];
  logic [DelayW-1:0] reload_value  [Depth];
  logic [DelayW-1:0] countdown     [Depth];
  logic [IdxW-1:0]   service_order [Depth];
  logic [Depth-1:0]  queued_flag;
  logic [LenW-1:0]   queue_length;
  logic [IdxW-1:0]   walk_idx;
  logic              pend_valid;
  logic [IdxW-1:0]   pend_slot;

  logic              slot_ok;
  logic [IdxW-1:0]   sidx;
  logic [DelayW-1:0] delay_p1;
  logic [IdxW-1:0]   cur;
  logic [DelayW-1:0] cur_cd;
  slot_mode_t        cur_mode;
  logic              cur_fires;
  logic              out_free;

  // Decode the start/stop target
  assign slot_ok  = (CmpW'(in_item.slot) < CmpW'(Depth));
  assign sidx     = in_item.slot[IdxW-1:0];
  assign delay_p1 = in_item.delay_ms + DelayW'(1);

  // Look up the slot under the walk
  assign cur       = service_order[walk_idx];
  assign cur_cd    = countdown[cur];
  assign cur_mode  = slot_mode[cur];
  assign cur_fires = (cur_mode != MODE_STOPPED) && (cur_cd <= DelayW'(1));

  assign out_free        = !out_valid || out_ready;
  assign stat.list_empty = (queue_length == '0);
  assign stat.walk_last  = (LenW'(walk_idx) == queue_length - 1'b1);
  assign stat.out_free   = out_free;

  // Slot state, list and walk; reload and countdown are only read after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        slot_mode[i] <= MODE_STOPPED;
      end
      queued_flag  <= '0;
      queue_length <= '0;
      walk_idx     <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (ctl.exec_setup && slot_ok) begin
        if (in_item.command == CMD_START) begin
          slot_mode[sidx]    <= in_item.mode ? MODE_LOOP : MODE_SINGLE;
          reload_value[sidx] <= delay_p1;
          countdown[sidx]    <= delay_p1;
          // Append on first start only
          if (!queued_flag[sidx] && (queue_length < LenW'(Depth))) begin
            service_order[queue_length[IdxW-1:0]] <= sidx;
            queue_length      <= queue_length + 1'b1;
            queued_flag[sidx] <= 1'b1;
          end
        end else begin
          slot_mode[sidx] <= MODE_STOPPED;
          countdown[sidx] <= DelayW'(1);
        end
      end

      if (ctl.walk_start) begin
        walk_idx <= '0;
      end

      // Tick: count down, saturating at one
      if (ctl.tick_step) begin
        if (cur_cd > DelayW'(1)) countdown[cur] <= cur_cd - DelayW'(1);
        walk_idx <= walk_idx + 1'b1;
      end

      // Poll: fire, then stop or reload
      if (ctl.poll_step) begin
        if (cur_fires) begin
          if (cur_mode == MODE_SINGLE) begin
            slot_mode[cur] <= MODE_STOPPED;
          end else begin
            countdown[cur] <= reload_value[cur];
          end
          pend_valid <= 1'b1;
          pend_slot  <= cur;
        end
        walk_idx <= walk_idx + 1'b1;
      end

      if (ctl.flush_step) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Output register: a fired slot is held back until the next one shows
  // whether it was the final result of the poll
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.poll_step && cur_fires && pend_valid) begin
        out_valid           <= 1'b1;
        out_item.fired      <= 1'b1;
        out_item.fired_slot <= SlotW'(pend_slot);
        out_item.last       <= 1'b0;
      end
      if (ctl.flush_step) begin
        out_valid           <= 1'b1;
        out_item.fired      <= pend_valid;
        out_item.fired_slot <= pend_valid ? SlotW'(pend_slot) : '0;
        out_item.last       <= 1'b1;
      end
    end
  end

  // List never grows past the slot count
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    queue_length <= LenW'(Depth))
    else $error("service list longer than slot count");

  // List never shrinks
  a_len_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> queue_length >= $past(queue_length))
    else $error("service list shrank");

  // An empty poll result is always the final one and names slot zero
  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.fired) |-> (out_item.last && out_item.fired_slot == '0))
    else $error("empty poll result malformed");

  // The walk never runs on an empty list
  a_walk_list: assert property (@(posedge clk) disable iff (rst)
    (ctl.tick_step || ctl.poll_step) |-> (queue_length != '0))
    else $error("walk step on empty list");

endmodule

`default_nettype wire
